[rtl/three_channel_ring_capture_top_defines.svh]
// Assertion macros shared by the ring capture RTL.
// No dependencies; pulled in by the modules that carry assertions.
`ifndef THREE_CHANNEL_RING_CAPTURE_TOP_DEFINES_SVH
`define THREE_CHANNEL_RING_CAPTURE_TOP_DEFINES_SVH

// plain property, checked every clock outside reset
`define TCRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define TCRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tcrc_pkg.sv]
// Shared constants and types for the three channel ring capture block.
// No dependencies; used by tcrc_ctrl and the top level of the block.
`default_nettype none

package tcrc_pkg;

    localparam int RING_DEPTH_DEF    = 1024;
    localparam int CHANNEL_COUNT_DEF = 3;
    localparam int SAMPLE_BITS_DEF   = 12;

    localparam int WIN_W   = 11;
    localparam int MEAN_W  = 16;
    localparam int FUNC_W  = 2;
    localparam int CHAN_W  = 2;
    localparam int FRAC_W  = 4;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 11'd100;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_POP  = 2'd1,
        FUNC_AVG  = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

endpackage

`default_nettype wire

[rtl/tcrc_store.sv]
// Sample store: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module tcrc_store #(
    parameter int DEPTH = 3072,
    parameter int AW    = 12,
    parameter int DW    = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/tcrc_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none

module tcrc_div #(
    parameter int DVD_W = 28,
    parameter int DSR_W = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DSR_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DSR_W-1:0] r_rem, n_rem;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DSR_W-1:0] r_dsr, n_dsr;
    logic [DSR_W:0]   rem_sh;
    logic [DSR_W:0]   diff;
    logic             ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[DVD_W-1]};
        ge     = (rem_sh >= {1'b0, r_dsr});
        diff   = rem_sh - {1'b0, r_dsr};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], ge};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

[rtl/tcrc_ctrl.sv]
// Request sequencer: ring pointers, fill counts, store access, window sum.
// Depends on tcrc_pkg and the assertion macros header.
`default_nettype none
`include "three_channel_ring_capture_top_defines.svh"

module tcrc_ctrl #(
    parameter int RING_DEPTH    = tcrc_pkg::RING_DEPTH_DEF,
    parameter int CHANNEL_COUNT = tcrc_pkg::CHANNEL_COUNT_DEF,
    parameter int SAMPLE_BITS   = tcrc_pkg::SAMPLE_BITS_DEF,
    localparam int PTR_W = $clog2(RING_DEPTH),
    localparam int CH_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1,
    localparam int AW    = CH_W + PTR_W,
    localparam int SUM_W = SAMPLE_BITS + tcrc_pkg::WIN_W,
    localparam int DVD_W = SUM_W + tcrc_pkg::FRAC_W
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [tcrc_pkg::FUNC_W-1:0] i_func,
    input  wire logic [SAMPLE_BITS-1:0]      i_sample,
    input  wire logic [tcrc_pkg::CHAN_W-1:0] i_channel,
    input  wire logic [tcrc_pkg::WIN_W-1:0]  i_window,
    output logic                             o_mem_we,
    output logic      [AW-1:0]               o_mem_waddr,
    output logic      [SAMPLE_BITS-1:0]      o_mem_wdata,
    output logic                             o_mem_re,
    output logic      [AW-1:0]               o_mem_raddr,
    input  wire logic [SAMPLE_BITS-1:0]      i_mem_rdata,
    output logic                             o_div_start,
    output logic      [DVD_W-1:0]            o_dividend,
    output logic      [tcrc_pkg::WIN_W-1:0]  o_divisor,
    input  wire logic                        i_div_done,
    input  wire logic [DVD_W-1:0]            i_div_quo,
    output logic                             o_res_valid,
    input  wire logic                        i_res_ready,
    output logic      [SAMPLE_BITS-1:0]      o_res_popped,
    output logic                             o_res_empty,
    output logic      [tcrc_pkg::MEAN_W-1:0] o_res_mean,
    output logic      [tcrc_pkg::WIN_W-1:0]  o_res_used
);

    localparam int WIN_W  = tcrc_pkg::WIN_W;
    localparam int MEAN_W = tcrc_pkg::MEAN_W;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_POP  = 5'b00010,
        S_SUM  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [PTR_W-1:0] r_wptr [CHANNEL_COUNT];
    logic [PTR_W-1:0] n_wptr [CHANNEL_COUNT];
    logic [PTR_W-1:0] r_rptr [CHANNEL_COUNT];
    logic [PTR_W-1:0] n_rptr [CHANNEL_COUNT];
    logic [CNT_W-1:0] r_fill [CHANNEL_COUNT];
    logic [CNT_W-1:0] n_fill [CHANNEL_COUNT];
    logic [CH_W-1:0]  r_phase, n_phase;
    logic             r_pend, n_pend;

    logic [CH_W-1:0]        r_ch, n_ch;
    logic [PTR_W-1:0]       r_idx, n_idx;
    logic [WIN_W-1:0]       r_left, n_left;
    logic [SUM_W-1:0]       r_acc, n_acc;
    logic [SAMPLE_BITS-1:0] r_popped, n_popped;
    logic                   r_empty, n_empty;
    logic [MEAN_W-1:0]      r_mean, n_mean;
    logic [WIN_W-1:0]       r_used, n_used;

    logic             ch_ok;
    logic [CH_W-1:0]  q_ch;
    logic [CNT_W-1:0] fill_q;
    logic [CMP_W-1:0] win_e, fill_e, n_full;
    logic [WIN_W-1:0] n_q;

    always_comb begin
        ch_ok  = (32'(i_channel) < CHANNEL_COUNT);
        q_ch   = CH_W'(i_channel);
        fill_q = ch_ok ? r_fill[q_ch] : '0;
        win_e  = CMP_W'(i_window);
        fill_e = CMP_W'(fill_q);
        n_full = (win_e < fill_e) ? win_e : fill_e;
        n_q    = WIN_W'(n_full);

        n_state  = r_state;
        n_wptr   = r_wptr;
        n_rptr   = r_rptr;
        n_fill   = r_fill;
        n_phase  = r_phase;
        n_pend   = r_pend;
        n_ch     = r_ch;
        n_idx    = r_idx;
        n_left   = r_left;
        n_acc    = r_acc;
        n_popped = r_popped;
        n_empty  = r_empty;
        n_mean   = r_mean;
        n_used   = r_used;

        o_mem_we    = 1'b0;
        o_mem_waddr = {r_phase, r_wptr[r_phase]};
        o_mem_wdata = i_sample;
        o_mem_re    = 1'b0;
        o_mem_raddr = {r_ch, r_idx};
        o_div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (tcrc_pkg::t_func'(i_func))
                        tcrc_pkg::FUNC_PUSH: begin
                            o_mem_we = 1'b1;
                            if (r_fill[r_phase] == CNT_W'(RING_DEPTH)) begin
                                n_rptr[r_phase] = r_rptr[r_phase] + PTR_W'(1);
                            end else begin
                                n_fill[r_phase] = r_fill[r_phase] + CNT_W'(1);
                            end
                            n_wptr[r_phase] = r_wptr[r_phase] + PTR_W'(1);
                            n_phase = (r_phase == CH_W'(CHANNEL_COUNT - 1)) ?
                                      '0 : r_phase + CH_W'(1);
                        end
                        tcrc_pkg::FUNC_POP: begin
                            n_popped = '0;
                            n_mean   = '0;
                            n_used   = '0;
                            if (fill_q == '0) begin
                                n_empty = 1'b1;
                                n_state = S_OUT;
                            end else begin
                                n_empty      = 1'b0;
                                o_mem_re     = 1'b1;
                                o_mem_raddr  = {q_ch, r_rptr[q_ch]};
                                n_rptr[q_ch] = r_rptr[q_ch] + PTR_W'(1);
                                n_fill[q_ch] = r_fill[q_ch] - CNT_W'(1);
                                n_state      = S_POP;
                            end
                        end
                        tcrc_pkg::FUNC_AVG: begin
                            n_popped = '0;
                            n_mean   = '0;
                            n_empty  = (fill_q == '0);
                            n_used   = n_q;
                            if (n_q == '0) begin
                                n_state = S_OUT;
                            end else begin
                                n_ch    = q_ch;
                                n_idx   = r_wptr[q_ch] - n_full[PTR_W-1:0];
                                n_left  = n_q;
                                n_acc   = '0;
                                n_pend  = 1'b0;
                                n_state = S_SUM;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                n_popped = i_mem_rdata;
                n_state  = S_OUT;
            end
            S_SUM: begin
                n_pend = (r_left != '0);
                if (r_left != '0) begin
                    o_mem_re = 1'b1;
                    n_idx    = r_idx + PTR_W'(1);
                    n_left   = r_left - WIN_W'(1);
                end
                if (r_pend) begin
                    n_acc = r_acc + SUM_W'(i_mem_rdata);
                end
                if (r_left == '0 && !r_pend) begin
                    o_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (i_div_done) begin
                    n_mean  = (|i_div_quo[DVD_W-1:MEAN_W]) ? '1 : i_div_quo[MEAN_W-1:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
            r_pend  <= 1'b0;
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_wptr[c] <= '0;
                r_rptr[c] <= '0;
                r_fill[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch     <= n_ch;
        r_idx    <= n_idx;
        r_left   <= n_left;
        r_acc    <= n_acc;
        r_popped <= n_popped;
        r_empty  <= n_empty;
        r_mean   <= n_mean;
        r_used   <= n_used;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_res_valid  = (r_state == S_OUT);
    assign o_res_popped = r_popped;
    assign o_res_empty  = r_empty;
    assign o_res_mean   = r_mean;
    assign o_res_used   = r_used;
    assign o_dividend   = {r_acc, {tcrc_pkg::FRAC_W{1'b0}}} + DVD_W'(r_used >> 1);
    assign o_divisor    = r_used;

    `TCRC_ASSERT(a_phase_range, i_clk, i_rst_n, (r_phase <= CH_W'(CHANNEL_COUNT - 1)), "phase out of range")
    `TCRC_ASSERT_IMP(a_div_done_state, i_clk, i_rst_n, i_div_done, (r_state == S_DIV), "divider done outside divide")
    `TCRC_ASSERT_IMP(a_sum_nonzero, i_clk, i_rst_n, (r_state == S_SUM), (r_used != '0), "summing an empty window")
    `TCRC_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, (o_res_valid && !i_res_ready), (o_res_valid && $stable(r_mean) && $stable(r_popped)), "result changed while held")

endmodule

`default_nettype wire

[rtl/three_channel_ring_capture_top.sv]
// Top level of the three channel ring capture block: window register,
// result register, sequencer, sample store and divider.
// Depends on tcrc_pkg, tcrc_ctrl, tcrc_store, tcrc_div.
//
// channel   direction  handshake              payload
// in        request    i_in_valid/o_in_stall  i_func, i_sample, i_channel
// out       result     o_out_valid/i_out_stall o_popped_value, o_was_empty,
//                                             o_mean_value, o_samples_used
// cfg       write      i_cfg_we               i_cfg_wdata (average window)
//
// A push completes in the idle state; a pop reads the store (S_POP) and then offers
// its result (S_OUT); an empty or zero-window query goes straight to S_OUT. Average does
// one store read per summed sample, then one quotient bit per cycle in the divider.
// Reset is synchronous; store contents are not cleared, no clearing pass.
// A held result sits in the output register while the next request runs;
// only a further result waits until i_out_stall drops.
`default_nettype none

module three_channel_ring_capture_top #(
    parameter int RING_DEPTH    = tcrc_pkg::RING_DEPTH_DEF,
    parameter int CHANNEL_COUNT = tcrc_pkg::CHANNEL_COUNT_DEF,
    parameter int SAMPLE_BITS   = tcrc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [tcrc_pkg::FUNC_W-1:0] i_func,
    input  wire logic [SAMPLE_BITS-1:0]      i_sample,
    input  wire logic [tcrc_pkg::CHAN_W-1:0] i_channel,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [SAMPLE_BITS-1:0]      o_popped_value,
    output logic                             o_was_empty,
    output logic      [tcrc_pkg::MEAN_W-1:0] o_mean_value,
    output logic      [tcrc_pkg::WIN_W-1:0]  o_samples_used,
    input  wire logic                        i_cfg_we,
    input  wire logic [tcrc_pkg::WIN_W-1:0]  i_cfg_wdata
);

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int AW     = CH_W + PTR_W;
    localparam int SUM_W  = SAMPLE_BITS + tcrc_pkg::WIN_W;
    localparam int DVD_W  = SUM_W + tcrc_pkg::FRAC_W;
    localparam int WIN_W  = tcrc_pkg::WIN_W;
    localparam int MEAN_W = tcrc_pkg::MEAN_W;

    logic [WIN_W-1:0]       r_window;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_popped;
    logic                   r_empty;
    logic [MEAN_W-1:0]      r_mean;
    logic [WIN_W-1:0]       r_used;

    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [SAMPLE_BITS-1:0] mem_wdata, mem_rdata;
    logic                   div_start, div_done;
    logic [DVD_W-1:0]       dividend, div_quo;
    logic [WIN_W-1:0]       divisor;
    logic                   res_valid, res_ready;
    logic [SAMPLE_BITS-1:0] res_popped;
    logic                   res_empty;
    logic [MEAN_W-1:0]      res_mean;
    logic [WIN_W-1:0]       res_used;

    tcrc_ctrl #(
        .RING_DEPTH    (RING_DEPTH),
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_sample     (i_sample),
        .i_channel    (i_channel),
        .i_window     (r_window),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata),
        .o_div_start  (div_start),
        .o_dividend   (dividend),
        .o_divisor    (divisor),
        .i_div_done   (div_done),
        .i_div_quo    (div_quo),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res_popped (res_popped),
        .o_res_empty  (res_empty),
        .o_res_mean   (res_mean),
        .o_res_used   (res_used)
    );

    tcrc_store #(
        .DEPTH (CHANNEL_COUNT * RING_DEPTH),
        .AW    (AW),
        .DW    (SAMPLE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tcrc_div #(
        .DVD_W (DVD_W),
        .DSR_W (WIN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= tcrc_pkg::WINDOW_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (res_ready) begin
                r_out_valid <= res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_popped <= res_popped;
            r_empty  <= res_empty;
            r_mean   <= res_mean;
            r_used   <= res_used;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_popped;
    assign o_was_empty    = r_empty;
    assign o_mean_value   = r_mean;
    assign o_samples_used = r_used;

endmodule

`default_nettype wire
